/* rtl/core/rrlc_pkg.sv */
// Shared types, tables and helper functions of the rotor reflector letter cipher.
package rrlc_pkg;

	localparam int ALPHA      = 26;
	localparam int ROTOR_ROWS = 9;
	localparam int REFL_ROWS  = 6;

	typedef logic [4:0] letter_t;
	typedef logic [3:0] rotor_type_t;
	typedef logic [2:0] refl_type_t;

	// input operation codes
	typedef enum logic [0:0] {
		OP_CIPHER = 1'b0,
		OP_LOAD   = 1'b1
	} opcode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LEFT_TYPE      = 3'd0,
		REG_MIDDLE_TYPE    = 3'd1,
		REG_RIGHT_TYPE     = 3'd2,
		REG_REFLECTOR_TYPE = 3'd3,
		REG_LEFT_START     = 3'd4,
		REG_MIDDLE_START   = 3'd5,
		REG_RIGHT_START    = 3'd6
	} cfg_idx_t;

	// rotor positions held in one memory word
	typedef struct packed {
		letter_t left;
		letter_t middle;
		letter_t right;
	} rotor_pos_t;

	localparam logic [7:0] ASCII_A = 8'd65;

	// rotor wiring rows, row 0 is identity
	localparam logic [0:ROTOR_ROWS-1][0:ALPHA-1][7:0] WIRING_ROWS = {
		"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
		"EKMFLGDQVZNTOWYHXUSPAIBRCJ",
		"AJDKSIRUXBLHWTMCQGZNPYFVOE",
		"BDFHJLCPRTXVZNYEIWGAKMUSQO",
		"ESOVPZJAYQUIRHXLNFTGKDCMWB",
		"VZBRGITYUPSDNHLXAWMJQOFECK",
		"JPGVOUMFYQBENHZRDKASXLICTW",
		"NZJHGRCXMYSWBOUFAIVLPEKQDT",
		"FKQHTLXOCBJSPDZRAMEWNIUYGV"
	};

	// reflector rows, row 0 is identity
	localparam logic [0:REFL_ROWS-1][0:ALPHA-1][7:0] REFLECT_ROWS = {
		"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
		"EJMZALYXVBWFCRQUONTSPIKHGD",
		"YRUHQSLDPXNGOKMIEBFZCWVJAT",
		"FVPJIAOYEDRZXWGCTKUQSBNMHL",
		"ENKQAUYWJICOPBLMDXZVFTHRGS",
		"RDOBJNTKVEHMLFCWZAXGYIPSUQ"
	};

	// wiring letter of a rotor; unknown types fall back to identity
	function automatic letter_t rotor_letter(rotor_type_t kind, letter_t pos);
		logic [3:0] row;
		logic [7:0] ch;
		row = (kind < 4'(ROTOR_ROWS)) ? kind : 4'd0;
		ch  = WIRING_ROWS[row][pos] - ASCII_A;
		return ch[4:0];
	endfunction

	// reflector letter; unknown types fall back to identity
	function automatic letter_t reflect_letter(refl_type_t kind, letter_t idx);
		logic [2:0] row;
		logic [7:0] ch;
		row = (kind < 3'(REFL_ROWS)) ? kind : 3'd0;
		ch  = REFLECT_ROWS[row][idx] - ASCII_A;
		return ch[4:0];
	endfunction

	// reduce a value below 130 mod 26
	function automatic letter_t mod26(logic [6:0] x);
		logic [6:0] r;
		if (x >= 7'd104) begin
			r = x - 7'd104;
		end else if (x >= 7'd78) begin
			r = x - 7'd78;
		end else if (x >= 7'd52) begin
			r = x - 7'd52;
		end else if (x >= 7'd26) begin
			r = x - 7'd26;
		end else begin
			r = x;
		end
		return r[4:0];
	endfunction

	// reduce a start position mod 26
	function automatic letter_t wrap_start(letter_t x);
		return (x >= 5'(ALPHA)) ? x - 5'(ALPHA) : x;
	endfunction

endpackage

/* rtl/core/rotor_reflector_letter_cipher.sv */
// Top level of the rotor reflector letter cipher: position memory, key and reflector stages.
// A cipher letter passes the key stage, the reflector stage and then the output register.
// Throughput: one letter per cycle unless the result side stalls; the rotor positions live
// in one memory word that is read on accept and written back when stage 1 completes, with
// a forward path across that gap. A load beat never stalls in stage 1 and gives no result.
// Reset: clears all configuration registers, pipeline valids and the position valid bit;
// until the first write the position word reads as all rotors at zero, so no clearing pass.
module rotor_reflector_letter_cipher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 opcode,
	input  rrlc_pkg::letter_t    letter_in,
	output logic                 res_valid,
	input  logic                 res_ready,
	output rrlc_pkg::letter_t    letter_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [4:0]           cfg_data
);
	import rrlc_pkg::*;

	// configuration registers
	rotor_type_t left_type_q, middle_type_q, right_type_q;
	refl_type_t  reflector_type_q;
	letter_t     left_start_q, middle_start_q, right_start_q;

	// position memory and its valid bit
	rotor_pos_t  pos_mem [1];
	logic        pos_vld_q;
	rotor_pos_t  pos_fwd_q;

	// stage 1: positions read, key formed
	logic        v_s1;
	opcode_t     op_s1;
	letter_t     letter_s1;
	rotor_pos_t  rdata_s1;
	logic        rvld_s1;
	logic        fwd_s1;

	// stage 2: reflector lookup
	logic        v_s2;
	letter_t     idx_s2;
	letter_t     krem_s2;

	// output register
	logic        out_valid_q;
	letter_t     out_letter_q;

	logic        item_accept;
	logic        s1_done;
	logic        s2_adv;
	rotor_pos_t  pos_cur;
	rotor_pos_t  pos_next;
	logic [6:0]  key;
	letter_t     idx_s1;
	letter_t     krem_s1;
	letter_t     refl;
	letter_t     res_letter;
	letter_t     r_inc, m_inc, l_inc;

	assign cfg_ready = 1'b1;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_type_q      <= '0;
			middle_type_q    <= '0;
			right_type_q     <= '0;
			reflector_type_q <= '0;
			left_start_q     <= '0;
			middle_start_q   <= '0;
			right_start_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_LEFT_TYPE:      left_type_q      <= cfg_data[3:0];
				REG_MIDDLE_TYPE:    middle_type_q    <= cfg_data[3:0];
				REG_RIGHT_TYPE:     right_type_q     <= cfg_data[3:0];
				REG_REFLECTOR_TYPE: reflector_type_q <= cfg_data[2:0];
				REG_LEFT_START:     left_start_q     <= cfg_data;
				REG_MIDDLE_START:   middle_start_q   <= cfg_data;
				REG_RIGHT_START:    right_start_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign s2_adv      = v_s2 && (!out_valid_q || res_ready);
	assign s1_done     = v_s1 && (op_s1 == OP_LOAD || !v_s2 || s2_adv);
	assign item_ready  = !v_s1 || s1_done;
	assign item_accept = item_valid && item_ready;

	// read and write the position word
	always_ff @(posedge clk) begin
		if (item_accept) begin
			rdata_s1 <= pos_mem[0];
		end
		if (s1_done) begin
			pos_mem[0] <= pos_next;
		end
	end

	// forward the word written at the same edge as the read
	always_comb begin
		if (fwd_s1) begin
			pos_cur = pos_fwd_q;
		end else if (rvld_s1) begin
			pos_cur = rdata_s1;
		end else begin
			pos_cur = '0;
		end
	end

	// form key, reflector index and key remainder
	always_comb begin
		key     = 7'(rotor_letter(left_type_q, pos_cur.left))
		        + 7'(rotor_letter(middle_type_q, pos_cur.middle))
		        + 7'(rotor_letter(right_type_q, pos_cur.right));
		idx_s1  = mod26(key + 7'(letter_s1));
		krem_s1 = mod26(key);
	end

	// advance the rotors odometer style, or load start positions
	always_comb begin
		r_inc = pos_cur.right + 5'd1;
		m_inc = pos_cur.middle + 5'd1;
		l_inc = pos_cur.left + 5'd1;
		pos_next = pos_cur;
		if (op_s1 == OP_LOAD) begin
			pos_next.left   = wrap_start(left_start_q);
			pos_next.middle = wrap_start(middle_start_q);
			pos_next.right  = wrap_start(right_start_q);
		end else if (r_inc != 5'(ALPHA)) begin
			pos_next.right = r_inc;
		end else begin
			pos_next.right = '0;
			if (m_inc != 5'(ALPHA)) begin
				pos_next.middle = m_inc;
			end else begin
				pos_next.middle = '0;
				pos_next.left   = (l_inc != 5'(ALPHA)) ? l_inc : 5'd0;
			end
		end
	end

	// reflect and remove the key
	always_comb begin
		refl       = reflect_letter(reflector_type_q, idx_s2);
		res_letter = (refl >= krem_s2) ? refl - krem_s2 : refl + 5'(ALPHA) - krem_s2;
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			pos_vld_q <= 1'b0;
		end else begin
			if (item_accept) begin
				v_s1 <= 1'b1;
			end else if (s1_done) begin
				v_s1 <= 1'b0;
			end
			if (s1_done) begin
				pos_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_s1     <= opcode_t'(opcode);
			letter_s1 <= letter_in;
			rvld_s1   <= pos_vld_q;
			fwd_s1    <= s1_done;
		end
		if (s1_done) begin
			pos_fwd_q <= pos_next;
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_done && op_s1 == OP_CIPHER) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && op_s1 == OP_CIPHER) begin
			idx_s2  <= idx_s1;
			krem_s2 <= krem_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_letter_q <= res_letter;
		end
	end

	assign res_valid  = out_valid_q;
	assign letter_out = out_letter_q;

	// positions seen by stage 1 stay in range
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (pos_cur.left < 5'(ALPHA) && pos_cur.middle < 5'(ALPHA)
			&& pos_cur.right < 5'(ALPHA)))
		else $error("rotor position out of range");

	// a stalled stage 1 holds its letter and operation
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_done) |=> (v_s1 && $stable(letter_s1) && $stable(op_s1)))
		else $error("stage 1 lost its beat while stalled");

	// a load beat never reaches the reflector stage
	a_load_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && op_s1 == OP_LOAD && (!v_s2 || s2_adv)) |=> !v_s2)
		else $error("load beat produced a result");

	// reflector stage operands are reduced
	a_s2_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (idx_s2 < 5'(ALPHA) && krem_s2 < 5'(ALPHA)))
		else $error("reflector operands out of range");

	// delivered letters are in range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_letter_q < 5'(ALPHA)))
		else $error("output letter out of range");

endmodule

/* bench/tb.sv */
// Testbench of the rotor reflector letter cipher: stimulus, letter predictor and scoreboard.
`timescale 1ns / 100ps

module tb;
	import rrlc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 93;

	// Predict enciphered letters and check them against the block's output.
	class cipher_scoreboard;
		string wiring_tab[9] = '{
			"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
			"EKMFLGDQVZNTOWYHXUSPAIBRCJ",
			"AJDKSIRUXBLHWTMCQGZNPYFVOE",
			"BDFHJLCPRTXVZNYEIWGAKMUSQO",
			"ESOVPZJAYQUIRHXLNFTGKDCMWB",
			"VZBRGITYUPSDNHLXAWMJQOFECK",
			"JPGVOUMFYQBENHZRDKASXLICTW",
			"NZJHGRCXMYSWBOUFAIVLPEKQDT",
			"FKQHTLXOCBJSPDZRAMEWNIUYGV"
		};
		string reflect_tab[6] = '{
			"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
			"EJMZALYXVBWFCRQUONTSPIKHGD",
			"YRUHQSLDPXNGOKMIEBFZCWVJAT",
			"FVPJIAOYEDRZXWGCTKUQSBNMHL",
			"ENKQAUYWJICOPBLMDXZVFTHRGS",
			"RDOBJNTKVEHMLFCWZAXGYIPSUQ"
		};
		// rotor order: 0 left, 1 middle, 2 right
		logic [3:0] rotor_kind[3];
		logic [2:0] refl_kind;
		logic [4:0] start_pos[3];
		int         rotor_pos[3];
		letter_t    expected_letters[$];
		int         errors;

		function new();
			foreach (rotor_kind[i]) begin
				rotor_kind[i] = '0;
				start_pos[i]  = '0;
				rotor_pos[i]  = 0;
			end
			refl_kind = '0;
			errors    = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [4:0] data);
			case (idx)
				REG_LEFT_TYPE:      rotor_kind[0] = data[3:0];
				REG_MIDDLE_TYPE:    rotor_kind[1] = data[3:0];
				REG_RIGHT_TYPE:     rotor_kind[2] = data[3:0];
				REG_REFLECTOR_TYPE: refl_kind     = data[2:0];
				REG_LEFT_START:     start_pos[0]  = data;
				REG_MIDDLE_START:   start_pos[1]  = data;
				REG_RIGHT_START:    start_pos[2]  = data;
				default: ;
			endcase
		endfunction

		// unknown rotor types fall back to the identity row
		function int wiring_letter(logic [3:0] kind, int p);
			int row;
			row = (kind < 9) ? int'(kind) : 0;
			return int'(wiring_tab[row][p]) - int'("A");
		endfunction

		function letter_t predict_letter(letter_t letter);
			int key, idx, row, refl;
			key = 0;
			foreach (rotor_pos[i])
				key += wiring_letter(rotor_kind[i], rotor_pos[i]);
			idx  = (int'(letter) + key) % 26;
			row  = (refl_kind < 6) ? int'(refl_kind) : 0;
			refl = int'(reflect_tab[row][idx]) - int'("A");
			return letter_t'((refl + 26 - key % 26) % 26);
		endfunction

		function void note_item(opcode_t op, letter_t letter);
			if (op == OP_LOAD) begin
				foreach (rotor_pos[i])
					rotor_pos[i] = int'(start_pos[i]) % 26;
				return;
			end
			expected_letters.push_back(predict_letter(letter));
			// step the right rotor, carry odometer-style to the left
			rotor_pos[2]++;
			if (rotor_pos[2] >= 26) begin
				rotor_pos[2] = 0;
				rotor_pos[1]++;
			end
			if (rotor_pos[1] >= 26) begin
				rotor_pos[1] = 0;
				rotor_pos[0]++;
			end
			if (rotor_pos[0] >= 26)
				rotor_pos[0] = 0;
		endfunction

		function void check_letter(letter_t got);
			letter_t want;
			if (expected_letters.size() == 0) begin
				$error("letter_out with no beat expected: actual %0d", got);
				errors++;
				return;
			end
			want = expected_letters.pop_front();
			if (got !== want) begin
				$error("letter_out mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic       opcode = OP_CIPHER;
	letter_t    letter_in = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	letter_t    letter_out;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = REG_LEFT_TYPE;
	logic [4:0] cfg_data = '0;

	cipher_scoreboard sb = new();
	bit  no_idle = 1'b0;
	bit  hold_request = 1'b0;
	int  cycles = 0;

	rotor_reflector_letter_cipher u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.opcode     (opcode),
		.letter_in  (letter_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.letter_out (letter_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// abort a run that hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// drive result ready: random stalls, long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				res_ready    <= 1'b0;
			end else begin
				res_ready <= no_idle || ($urandom_range(0, 99) >= 26);
			end
		end
	end

	// check each result beat
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_letter(letter_out);
	end

	// offer one input beat, idling at random first
	task automatic send_item(opcode_t op, letter_t letter);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 26) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		letter_in  <= letter;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(op, letter);
	endtask

	task automatic stop_items();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// wait for every expected letter, then let a trailing load settle
	task automatic wait_drained();
		while (sb.expected_letters.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all registers in index order
	task automatic write_config(input logic [4:0] vals[7]);
		cfg_idx_t idx;
		idx = idx.first();
		for (int i = 0; i < 7; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(idx, vals[i]);
			idx = idx.next();
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// pick register values, favoring legal ranges and their top ends
	task automatic random_config(output logic [4:0] vals[7]);
		int top[7] = '{8, 8, 8, 5, 25, 25, 25};
		for (int i = 0; i < 7; i++) begin
			case ($urandom_range(0, 5))
				0:       vals[i] = 5'($urandom_range(0, 31));
				1:       vals[i] = 5'(top[i]);
				2:       vals[i] = '0;
				default: vals[i] = 5'($urandom_range(0, top[i]));
			endcase
		end
	endtask

	function automatic letter_t random_letter();
		if ($urandom_range(0, 99) < 85)
			return letter_t'($urandom_range(0, 25));
		return letter_t'($urandom_range(26, 31));
	endfunction

	initial begin
		logic [4:0] cfg_vals[7];
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset config: identity rotors and reflector
		send_item(OP_CIPHER, 5'd0);
		send_item(OP_CIPHER, 5'd25);
		send_item(OP_CIPHER, 5'd31);
		stop_items();
		wait_drained();

		// top legal and unknown types; starts set so the rotors wrap together
		cfg_vals = '{5'd8, 5'd15, 5'd1, 5'd5, 5'd25, 5'd25, 5'd24};
		write_config(cfg_vals);
		send_item(OP_LOAD, 5'd17);
		send_item(OP_CIPHER, 5'd7);
		send_item(OP_CIPHER, 5'd0);
		send_item(OP_CIPHER, 5'd25);
		send_item(OP_CIPHER, 5'd31);
		stop_items();
		wait_drained();

		// unknown reflector, out-of-range starts, upper data bit on type fields
		cfg_vals = '{5'd9, 5'd20, 5'd31, 5'd7, 5'd30, 5'd26, 5'd31};
		write_config(cfg_vals);
		send_item(OP_LOAD, 5'd0);
		send_item(OP_CIPHER, 5'd0);
		send_item(OP_CIPHER, 5'd13);
		send_item(OP_CIPHER, 5'd25);
		send_item(OP_CIPHER, 5'd26);
		send_item(OP_CIPHER, 5'd31);
		send_item(OP_LOAD, 5'd31);
		send_item(OP_CIPHER, 5'd21);
		stop_items();
		wait_drained();

		// random phases, each opened by a position load
		for (int ph = 0; ph < PHASES; ph++) begin
			random_config(cfg_vals);
			if (ph == PHASES - 1)
				cfg_vals = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
			write_config(cfg_vals);
			no_idle = (ph == 3);
			if (ph == 2)
				hold_request = 1'b1;
			send_item(OP_LOAD, random_letter());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == PHASE_ITEMS / 2) begin
					stop_items();
					while (sb.expected_letters.size() != 0)
						@(posedge clk);
				end
				if ($urandom_range(0, 99) < 8)
					send_item(OP_LOAD, random_letter());
				else
					send_item(OP_CIPHER, random_letter());
			end
			no_idle = 1'b0;
			stop_items();
			wait_drained();
		end

		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.expected_letters.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
